@@ rtl/core/lfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types, codes and sizes of the STX/ETX line-frame receiver.
// ----------------------------------------------------------------------------
package lfr_pkg;

    localparam int NUM_LINES  = 16;
    localparam int LINE_CHARS = 32;
    localparam int STORE_DEPTH = NUM_LINES * LINE_CHARS;
    localparam int ADDR_W     = $clog2(STORE_DEPTH);

    localparam int ACT_W  = 2;
    localparam int CHAR_W = 7;
    localparam int RL_W   = 4;
    localparam int RC_W   = 5;
    localparam int LINE_W = 5;
    localparam int COL_W  = 6;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    localparam logic [ACT_W-1:0] ACT_BYTE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TIMEOUT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_READ    = 2'd3;

    localparam logic [CHAR_W-1:0] CHR_STX = 7'h02;
    localparam logic [CHAR_W-1:0] CHR_ETX = 7'h03;
    localparam logic [CHAR_W-1:0] CHR_LF  = 7'h0A;
    localparam logic [CHAR_W-1:0] CHR_CR  = 7'h0D;

    localparam logic [LINE_W-1:0] LINE_MAX = LINE_W'(NUM_LINES);
    localparam logic [COL_W-1:0]  COL_MAX  = COL_W'(LINE_CHARS);

    // controller to datapath
    typedef struct packed {
        logic load;    // input word taken
        logic commit;  // apply step, load result register
        logic sweep;   // zero one store entry
    } lfr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_clear;
        logic sweep_last;
    } lfr_stat_t;

    function automatic logic [ADDR_W-1:0] store_addr(input logic [LINE_W-1:0] l,
                                                     input logic [COL_W-1:0]  c);
        store_addr = ADDR_W'(l) * ADDR_W'(LINE_CHARS) + ADDR_W'(c);
    endfunction

endpackage

@@ rtl/core/lfr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/lfr_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_datapath
// Frame state, character store and result register of the line receiver.
// ----------------------------------------------------------------------------
module lfr_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lfr_pkg::lfr_cmd_t              cmd,
    output lfr_pkg::lfr_stat_t             stat,
    input  logic [lfr_pkg::IN_DATA_W-1:0]  in_data,
    input  logic [lfr_pkg::ACT_W-1:0]      in_act,
    output logic [lfr_pkg::OUT_DATA_W-1:0] out_data
);
    import lfr_pkg::*;

    logic [ACT_W-1:0]  act_reg;
    logic [CHAR_W-1:0] byte_reg;
    logic              rd_ok_reg;

    logic              cap_reg,  cap_next;
    logic              done_reg, done_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [COL_W-1:0]  col_reg,  col_next;
    logic [ADDR_W-1:0] sweep_reg;

    logic [CHAR_W-1:0] rd_char;
    logic              wr_char;
    logic [CHAR_W-1:0] ram_q;

    logic [CHAR_W-1:0] in_byte;
    logic [RL_W-1:0]   in_rl;
    logic [RC_W-1:0]   in_rc;

    logic [OUT_DATA_W-1:0] out_reg;

    assign in_byte = in_data[CHAR_W-1:0];
    assign in_rl   = in_data[CHAR_W+RL_W-1:CHAR_W];
    assign in_rc   = in_data[CHAR_W+RL_W+RC_W-1:CHAR_W+RL_W];

    // input latch; the store read is issued in the same cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= in_act;
            byte_reg  <= in_byte;
            rd_ok_reg <= ({1'b0, in_rl} < LINE_MAX) && ({1'b0, in_rc} < COL_MAX);
        end
    end

    always_comb
    begin
        cap_next  = cap_reg;
        done_next = done_reg;
        line_next = line_reg;
        col_next  = col_reg;
        rd_char   = '0;
        wr_char   = 1'b0;
        unique case (act_reg)
            ACT_BYTE:
            begin
                if (!done_reg)
                begin
                    if (byte_reg == CHR_STX)
                    begin
                        cap_next  = 1'b1;
                        done_next = 1'b0;
                    end
                    else if (cap_reg)
                    begin
                        if (byte_reg == CHR_ETX)
                        begin
                            cap_next  = 1'b0;
                            done_next = 1'b1;
                        end
                        else if (byte_reg == CHR_LF)
                        begin
                            if (line_reg < LINE_MAX)
                            begin
                                line_next = line_reg + LINE_W'(1);
                                col_next  = '0;
                            end
                        end
                        else if (byte_reg != CHR_CR)
                        begin
                            if (col_reg < COL_MAX)
                            begin
                                wr_char  = (line_reg < LINE_MAX);
                                col_next = col_reg + COL_W'(1);
                            end
                        end
                    end
                end
            end
            ACT_TIMEOUT:
            begin
                cap_next = 1'b0;
            end
            ACT_CLEAR:
            begin
                cap_next  = 1'b0;
                done_next = 1'b0;
                line_next = '0;
                col_next  = '0;
            end
            ACT_READ:
            begin
                rd_char = rd_ok_reg ? ram_q : '0;
            end
            default:
            begin
                rd_char = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= 1'b0;
            done_reg  <= 1'b0;
            line_reg  <= '0;
            col_reg   <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            if (cmd.commit)
            begin
                cap_reg  <= cap_next;
                done_reg <= done_next;
                line_reg <= line_next;
                col_reg  <= col_next;
            end
            if (cmd.sweep)
            begin
                sweep_reg <= stat.sweep_last ? '0 : sweep_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_reg <= {4'b0, col_next, line_next, done_next, cap_next, rd_char};
        end
    end

    assign out_data = out_reg;

    assign stat.is_clear   = (act_reg == ACT_CLEAR);
    assign stat.sweep_last = (sweep_reg == ADDR_W'(STORE_DEPTH - 1));

    lfr_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.sweep || (cmd.commit && wr_char)),
        .waddr (cmd.sweep ? sweep_reg : store_addr(line_reg, col_reg)),
        .wdata (cmd.sweep ? '0 : byte_reg),
        .re    (cmd.load),
        .raddr (store_addr({1'b0, in_rl}, {1'b0, in_rc})),
        .rdata (ram_q)
    );

endmodule

@@ rtl/core/lfr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_ctrl
// Sequencer: accept, execute with output hand-off, and store clearing sweep.
// ----------------------------------------------------------------------------
module lfr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  lfr_pkg::lfr_stat_t stat,
    output lfr_pkg::lfr_cmd_t  cmd
);
    import lfr_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;
    logic       out_free;

    assign s_tready   = (state_reg == ST_IDLE);
    assign out_free   = !mvalid_reg || m_tready;
    assign cmd.load   = s_tvalid && s_tready;
    assign cmd.commit = (state_reg == ST_EXEC) && out_free;
    assign cmd.sweep  = (state_reg == ST_SWEEP);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = stat.is_clear ? ST_SWEEP : ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mvalid_next = mvalid_reg;
        if (cmd.commit)
        begin
            mvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            mvalid_next = 1'b0;
        end
    end

    // reset starts with a sweep so the store reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_SWEEP;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;

endmodule

@@ rtl/core/stx_etx_line_frame_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stx_etx_line_frame_receiver
// Captures one STX/ETX framed message into a 16 x 32 character line store.
// ----------------------------------------------------------------------------
//  channel  dir  signals                   fields (lowest bit up)
//  s        in   tvalid tready tdata tuser  tdata: rx_byte, read_line,
//                                           read_column; tuser: action
//  m        out  tvalid tready tdata        tdata: read_char, capturing,
//                                           frame_done, line_now, column_now
//
//  Each word is accepted (store read issued), then executed, and the
//  execute step waits only if the result register is still held by m.
//  A new word is accepted while a result waits to be taken.
//  After reset and after each clear the store is zeroed by a sweep of
//  all 512 entries, one entry a cycle, with s_tready low.
// ----------------------------------------------------------------------------
module stx_etx_line_frame_receiver (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // rx_byte[6:0], read_line[10:7], read_column[15:11]
    input  logic [lfr_pkg::IN_DATA_W-1:0]  s_tdata,
    // action[1:0]
    input  logic [lfr_pkg::ACT_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_char[6:0], capturing[7], frame_done[8], line_now[13:9],
    // column_now[19:14], zero fill [23:20]
    output logic [lfr_pkg::OUT_DATA_W-1:0] m_tdata
);
    import lfr_pkg::*;

    lfr_cmd_t  cmd;
    lfr_stat_t stat;

    lfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lfr_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_data  (s_tdata),
        .in_act   (s_tuser),
        .out_data (m_tdata)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("word accepted while previous one in flight");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[7] && m_tdata[8]))
        else $error("capturing and frame_done both set");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[13:9] <= LINE_MAX) && (m_tdata[19:14] <= COL_MAX)))
        else $error("line or column index beyond limit");

    a_clear_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && stat.is_clear) |=> (cmd.sweep && !s_tready))
        else $error("clear did not start store sweep");

endmodule

@@ tb/stx_etx_line_frame_receiver_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stx_etx_line_frame_receiver_tb
// Self-checking bench for the STX/ETX line-frame receiver. A scoreboard keeps
// its own copy of the flags, indices and line store, predicts the status word
// of every accepted input word and compares it field by field with the output
// stream. Directed words cover the idle, done and restart cases, then framed
// text with random content, saturating lines and columns, reads and clears,
// mixed with noise, under random gaps, stalls and one long output hold.
// ----------------------------------------------------------------------------
module stx_etx_line_frame_receiver_tb;

    import lfr_pkg::*;

    localparam int ITEM_TARGET    = 550;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int HOLD_AFTER     = 120;  // results taken before the long hold
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        logic [CHAR_W-1:0] read_char;
        logic              capturing;
        logic              frame_done;
        logic [LINE_W-1:0] line_now;
        logic [COL_W-1:0]  column_now;
    } rx_status_t;

    class frame_scoreboard;
        bit                capture;
        bit                done;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
        logic [CHAR_W-1:0] store [NUM_LINES][LINE_CHARS];
        rx_status_t        status_q [$];
        int                errors;
        int                n_words;
        int                n_effective;
        int                n_frames;
        int                n_dropped;
        int                n_lf_held;
        int                n_clears;
        int                n_reads;

        function new();
            wipe();
        endfunction

        function void wipe();
            capture = 1'b0;
            done    = 1'b0;
            line    = '0;
            col     = '0;
            foreach (store[l, c])
                store[l][c] = '0;
        endfunction

        // returns 1 when the character changed the state
        function bit take_char(logic [CHAR_W-1:0] ch);
            if (done)
                return 1'b0;
            if (ch == CHR_STX)
            begin
                capture = 1'b1;
                return 1'b1;
            end
            if (!capture || ch == CHR_CR)
                return 1'b0;
            if (ch == CHR_ETX)
            begin
                capture = 1'b0;
                done    = 1'b1;
                n_frames++;
                return 1'b1;
            end
            if (ch == CHR_LF)
            begin
                if (line < LINE_MAX)
                begin
                    line++;
                    col = '0;
                    return 1'b1;
                end
                n_lf_held++;
                return 1'b0;
            end
            if (col >= COL_MAX)
            begin
                n_dropped++;
                return 1'b0;
            end
            // past the last line only the column moves
            if (line < LINE_MAX)
                store[line][col] = ch;
            col++;
            return 1'b1;
        endfunction

        function void note_word(logic [ACT_W-1:0] act, logic [CHAR_W-1:0] ch,
                                logic [RL_W-1:0] rl, logic [RC_W-1:0] rc);
            rx_status_t st;
            bit         effect;
            st.read_char = '0;
            effect       = 1'b1;
            case (act)
                ACT_BYTE:    effect = take_char(ch);
                ACT_TIMEOUT:
                begin
                    effect  = capture;
                    capture = 1'b0;
                end
                ACT_CLEAR:
                begin
                    wipe();
                    n_clears++;
                end
                default:
                begin
                    if (int'(rl) < NUM_LINES && int'(rc) < LINE_CHARS)
                        st.read_char = store[rl][rc];
                    n_reads++;
                end
            endcase
            st.capturing  = capture;
            st.frame_done = done;
            st.line_now   = line;
            st.column_now = col;
            status_q.push_back(st);
            n_words++;
            if (effect)
                n_effective++;
        endfunction

        function void report(string what, int exp_val, int act_val);
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h",
                     $time, what, exp_val, act_val);
        endfunction

        function void check_word(logic [OUT_DATA_W-1:0] data);
            rx_status_t exp_st;
            if (status_q.size() == 0)
            begin
                report("unexpected word", 0, int'(data));
                return;
            end
            exp_st = status_q.pop_front();
            if (data[6:0] !== exp_st.read_char)
                report("read_char", int'(exp_st.read_char), int'(data[6:0]));
            if (data[7] !== exp_st.capturing)
                report("capturing", int'(exp_st.capturing), int'(data[7]));
            if (data[8] !== exp_st.frame_done)
                report("frame_done", int'(exp_st.frame_done), int'(data[8]));
            if (data[13:9] !== exp_st.line_now)
                report("line_now", int'(exp_st.line_now), int'(data[13:9]));
            if (data[19:14] !== exp_st.column_now)
                report("column_now", int'(exp_st.column_now), int'(data[19:14]));
            if (data[23:20] !== 4'h0)
                report("zero fill", 0, int'(data[23:20]));
        endfunction

        function int pending();
            return status_q.size();
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [ACT_W-1:0]      s_tuser  = ACT_BYTE;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    frame_scoreboard sb;
    bit              no_gaps    = 1'b0;
    bit              no_stalls  = 1'b0;
    int              idle_count = 0;
    int              taken      = 0;

    stx_etx_line_frame_receiver i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // handshake signals are sampled right after the edge, i.e. pre-edge values
    task automatic send_word(logic [ACT_W-1:0] act, logic [CHAR_W-1:0] ch,
                             logic [RL_W-1:0] rl, logic [RC_W-1:0] rc);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rc, rl, ch};
        s_tuser  <= act;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_word(act, ch, rl, rc);
    endtask

    task automatic send_char(logic [CHAR_W-1:0] ch);
        send_word(ACT_BYTE, ch, RL_W'($urandom), RC_W'($urandom));
    endtask

    task automatic send_read(logic [RL_W-1:0] rl, logic [RC_W-1:0] rc);
        send_word(ACT_READ, CHAR_W'($urandom), rl, rc);
    endtask

    task automatic send_plain(logic [ACT_W-1:0] act);
        send_word(act, CHAR_W'($urandom), RL_W'($urandom), RC_W'($urandom));
    endtask

    function automatic logic [CHAR_W-1:0] text_char();
        logic [CHAR_W-1:0] c;
        do
            c = CHAR_W'($urandom_range(0, 127));
        while (c == CHR_STX || c == CHR_ETX || c == CHR_LF || c == CHR_CR);
        return c;
    endfunction

    task automatic run_frame();
        int mode;
        int n_lines;
        int n_chars;
        mode    = $urandom_range(0, 9);
        n_lines = (mode == 0) ? $urandom_range(17, 19) : $urandom_range(1, 4);
        send_char(CHR_STX);
        for (int l = 0; l < n_lines; l++)
        begin
            n_chars = (mode == 1) ? $urandom_range(30, 36) : $urandom_range(0, 8);
            repeat (n_chars) send_char(text_char());
            if ($urandom_range(0, 3) == 0)
                send_char(CHR_CR);
            if ($urandom_range(0, 19) == 0)
                send_plain(ACT_TIMEOUT);
            if (l != n_lines - 1)
                send_char(CHR_LF);
        end
        if ($urandom_range(0, 9) != 0)
            send_char(CHR_ETX);
        repeat ($urandom_range(2, 6))
        begin
            if ($urandom_range(0, 3) == 0)
                send_read(RL_W'($urandom), RC_W'($urandom));
            else
                send_read(RL_W'($urandom_range(0, 3)), RC_W'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 2) == 0)
            send_plain(ACT_CLEAR);
    endtask

    task automatic send_noise();
        logic [ACT_W-1:0] act;
        act = ACT_W'($urandom_range(0, 3));
        if (act == ACT_CLEAR && $urandom_range(0, 3) != 0)
            act = ACT_BYTE;
        send_plain(act);
    endtask

    // output side: random stall before each word, one long hold
    initial
    begin
        int stall;
        forever
        begin
            if (taken == HOLD_AFTER)
                stall = HOLD_CYCLES;
            else
                stall = no_stalls ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            sb.check_word(m_tdata);
            taken++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            if (idle_count >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("stx_etx_line_frame_receiver_tb: errors");
                $finish;
            end
        end
    end

    initial
    begin
        int frame_no;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: idle behavior, capture, restart, done lockout, clear
        send_read(4'd0, 5'd0);
        send_read(4'd15, 5'd31);
        send_char(7'h41);
        send_char(CHR_ETX);
        send_plain(ACT_TIMEOUT);
        send_char(7'h7F);
        send_char(CHR_STX);
        send_char(7'h48);
        send_char(7'h7F);
        send_char(7'h00);
        send_char(CHR_CR);
        send_char(CHR_LF);
        send_char(7'h55);
        send_char(CHR_STX);
        send_plain(ACT_TIMEOUT);
        send_char(7'h41);
        send_char(CHR_STX);
        send_char(CHR_ETX);
        send_char(CHR_STX);
        send_char(7'h42);
        send_plain(ACT_TIMEOUT);
        send_read(4'd0, 5'd0);
        send_read(4'd0, 5'd1);
        send_read(4'd1, 5'd0);
        send_plain(ACT_CLEAR);
        send_read(4'd0, 5'd0);

        frame_no = 0;
        while (sb.n_words < ITEM_TARGET)
        begin
            no_gaps   = (frame_no % 4 == 3);
            no_stalls = (frame_no % 4 == 3);
            if ($urandom_range(0, 99) < 70)
                run_frame();
            else
                repeat ($urandom_range(1, 6)) send_noise();
            frame_no++;
        end
        no_gaps   = 1'b0;
        no_stalls = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d words (%0d effective), %0d reads, %0d clears, %0d frames closed",
                 sb.n_words, sb.n_effective, sb.n_reads, sb.n_clears, sb.n_frames);
        $display("run: %0d chars dropped at full line, %0d LF at last line, %0d errors",
                 sb.n_dropped, sb.n_lf_held, sb.errors);
        if (sb.errors == 0)
            $display("stx_etx_line_frame_receiver_tb: clean");
        else
            $display("stx_etx_line_frame_receiver_tb: errors");
        $finish;
    end

endmodule
